>>> sv/bmx_pkg.sv
package bmx_pkg;

    localparam int VAL_W  = 31;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_DCHK,
        ST_DUPD,
        ST_QRY,
        ST_FLUSH,
        ST_FIN
    } t_state;

endpackage

>>> sv/bmx_node_mem.sv
// Node store: one write port, two registered read ports.
module bmx_node_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 44
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> sv/binary_trie_max_xor_unit.sv
// Multiset of 31-bit values kept as a binary trie with a count per node.
// Input channel (i_valid / o_ready) takes one word: i_req_type (insert,
// delete one copy, max-xor query, clear) and i_value. Output channel
// (o_valid / i_ready) returns one word per request: o_max_xor, o_status.
// One request is worked at a time. The walk handles one trie level per
// step: the node store reads both children of the current node at once,
// so the walk is bounded by one memory access per level.
//   insert : walk down allocating nodes, then leaf write-back
//   delete : presence walk, then count update walk, then leaf write-back
//   query  : one walk, taking the side against each key bit if it holds values
//   clear, rejected or flagged requests : straight to the result
// The root lives in flops; every other node lives in the node store and
// is written when allocated, so reset needs no clearing pass: after
// reset the set is empty and the allocator points at node 2.
// The result sits in an output register. A new request is taken while
// it waits; if the receiver stalls, the next finished request holds in
// its final state until the output register frees up.
module binary_trie_max_xor_unit #(
    parameter int KEY_BITS   = 31,
    parameter int NODE_POOL  = 16384,
    parameter int COUNT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bmx_pkg::REQ_W-1:0]   i_req_type,
    input  logic [bmx_pkg::VAL_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bmx_pkg::VAL_W-1:0]   o_max_xor,
    output logic [bmx_pkg::STAT_W-1:0]  o_status
);

    localparam int NW  = $clog2(NODE_POOL);          // node index width
    localparam int FW  = NW + 1;                     // allocator can reach NODE_POOL
    localparam int CW  = COUNT_BITS;
    localparam int RW  = 2 * NW + CW;                // {zero kid, one kid, count}
    localparam int LVW = $clog2(KEY_BITS + 1);
    localparam int KW  = (KEY_BITS > bmx_pkg::VAL_W) ? KEY_BITS : bmx_pkg::VAL_W;
    // insert rejected once fewer than KEY_BITS nodes remain
    localparam logic [FW-1:0] FREE_MAX = FW'(NODE_POOL - KEY_BITS);
    localparam logic [FW-1:0] FREE_INIT = FW'(2);

    // ---- registers ----
    bmx_pkg::t_state r_state, n_state;
    logic [KEY_BITS-1:0] r_key,  n_key;      // remaining key bits, msb first
    logic [KEY_BITS-1:0] r_key0, n_key0;     // saved key for the delete update walk
    logic [KEY_BITS-1:0] r_best, n_best;
    logic [LVW-1:0]      r_lvl,  n_lvl;
    logic [NW-1:0]       r_node, n_node;     // current node (non-root)
    logic                r_at_root, n_at_root;
    logic [NW-1:0]       r_k0, n_k0;         // current node's children; their next values are the read addresses
    logic [NW-1:0]       r_k1, n_k1;
    logic [CW-1:0]       r_cnt, n_cnt;       // current node's updated count
    logic [FW-1:0]       r_free, n_free;
    logic [NW-1:0]       r_root_k0, n_root_k0;
    logic [NW-1:0]       r_root_k1, n_root_k1;
    logic [CW-1:0]       r_root_cnt, n_root_cnt;
    logic [bmx_pkg::STAT_W-1:0] r_status, n_status;
    logic                r_o_valid, n_o_valid;
    logic [bmx_pkg::VAL_W-1:0]  r_o_max, n_o_max;
    logic [bmx_pkg::STAT_W-1:0] r_o_status, n_o_status;

    // ---- node store ----
    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata;
    logic [RW-1:0] rd_a;   // record of r_k0
    logic [RW-1:0] rd_b;   // record of r_k1

    bmx_node_mem #(
        .DEPTH (NODE_POOL),
        .AW    (NW),
        .DW    (RW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (n_k0),
        .i_raddr_b (n_k1),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // ---- record fields of the two children just read ----
    logic [NW-1:0] a_k0, a_k1, b_k0, b_k1;
    logic [CW-1:0] a_cnt, b_cnt;
    assign a_k0  = rd_a[RW-1 -: NW];
    assign a_k1  = rd_a[RW-NW-1 -: NW];
    assign a_cnt = rd_a[CW-1:0];
    assign b_k0  = rd_b[RW-1 -: NW];
    assign b_k1  = rd_b[RW-NW-1 -: NW];
    assign b_cnt = rd_b[CW-1:0];

    logic          key_bit;
    logic          last_lvl;
    logic [NW-1:0] sel_ptr, sel_k0, sel_k1;   // child along the key bit
    logic [CW-1:0] sel_cnt;
    logic [NW-1:0] opp_ptr, opp_k0, opp_k1;   // child against the key bit
    logic [CW-1:0] opp_cnt;
    logic          alloc;
    logic [NW-1:0] new_ptr, pk0, pk1;
    logic          take_opp;
    logic [KW-1:0] val_ext;
    logic [KW-1:0] best_ext;

    assign key_bit  = r_key[KEY_BITS-1];
    assign last_lvl = (r_lvl == LVW'(1));
    assign sel_ptr  = key_bit ? r_k1  : r_k0;
    assign sel_k0   = key_bit ? b_k0  : a_k0;
    assign sel_k1   = key_bit ? b_k1  : a_k1;
    assign sel_cnt  = key_bit ? b_cnt : a_cnt;
    assign opp_ptr  = key_bit ? r_k0  : r_k1;
    assign opp_k0   = key_bit ? a_k0  : b_k0;
    assign opp_k1   = key_bit ? a_k1  : b_k1;
    assign opp_cnt  = key_bit ? a_cnt : b_cnt;

    // insert: grab a fresh node when the path ends here
    assign alloc   = (sel_ptr == '0);
    assign new_ptr = alloc ? r_free[NW-1:0] : sel_ptr;
    assign pk0     = (!key_bit && alloc) ? new_ptr : r_k0;
    assign pk1     = ( key_bit && alloc) ? new_ptr : r_k1;

    // query: go against the key bit when that side still holds values
    assign take_opp = (opp_ptr != '0) && (opp_cnt != '0);

    assign val_ext  = KW'(i_value);
    assign best_ext = KW'(r_best);

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_key0     = r_key0;
        n_best     = r_best;
        n_lvl      = r_lvl;
        n_node     = r_node;
        n_at_root  = r_at_root;
        n_k0       = r_k0;
        n_k1       = r_k1;
        n_cnt      = r_cnt;
        n_free     = r_free;
        n_root_k0  = r_root_k0;
        n_root_k1  = r_root_k1;
        n_root_cnt = r_root_cnt;
        n_status   = r_status;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_max    = r_o_max;
        n_o_status = r_o_status;
        mem_we     = 1'b0;
        mem_waddr  = r_node;
        mem_wdata  = {r_k0, r_k1, r_cnt};
        o_ready    = 1'b0;

        case (r_state)
            bmx_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_best    = '0;
                    n_key     = val_ext[KEY_BITS-1:0];
                    n_key0    = val_ext[KEY_BITS-1:0];
                    n_lvl     = LVW'(KEY_BITS);
                    n_at_root = 1'b1;
                    n_k0      = r_root_k0;
                    n_k1      = r_root_k1;
                    n_status  = bmx_pkg::STAT_OK;
                    n_state   = bmx_pkg::ST_FIN;
                    case (i_req_type)
                        bmx_pkg::REQ_INSERT: begin
                            if ((r_free > FREE_MAX) || (&r_root_cnt)) begin
                                n_status = bmx_pkg::STAT_NO_ROOM;
                            end else begin
                                n_root_cnt = r_root_cnt + CW'(1);
                                n_state    = bmx_pkg::ST_INS;
                            end
                        end
                        bmx_pkg::REQ_DELETE: begin
                            if (r_root_cnt == '0) begin
                                n_status = bmx_pkg::STAT_ABSENT;
                            end else begin
                                n_state = bmx_pkg::ST_DCHK;
                            end
                        end
                        bmx_pkg::REQ_QUERY: begin
                            if (r_root_cnt == '0) begin
                                n_status = bmx_pkg::STAT_EMPTY;
                            end else begin
                                n_state = bmx_pkg::ST_QRY;
                            end
                        end
                        bmx_pkg::REQ_CLEAR: begin
                            n_free     = FREE_INIT;
                            n_root_k0  = '0;
                            n_root_k1  = '0;
                            n_root_cnt = '0;
                        end
                        default: begin
                            n_state = bmx_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            bmx_pkg::ST_INS: begin
                // write back the parent with its (maybe new) child link
                if (r_at_root) begin
                    n_root_k0 = pk0;
                    n_root_k1 = pk1;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = {pk0, pk1, r_cnt};
                end
                if (alloc) begin
                    n_free = r_free + FW'(1);
                end
                n_node    = new_ptr;
                n_at_root = 1'b0;
                n_k0      = alloc ? '0 : sel_k0;
                n_k1      = alloc ? '0 : sel_k1;
                n_cnt     = (alloc ? '0 : sel_cnt) + CW'(1);
                n_key     = r_key << 1;
                n_lvl     = r_lvl - LVW'(1);
                if (last_lvl) begin
                    n_state = bmx_pkg::ST_FLUSH;
                end
            end

            bmx_pkg::ST_DCHK: begin
                if ((sel_ptr == '0) || (sel_cnt == '0)) begin
                    n_status = bmx_pkg::STAT_ABSENT;
                    n_state  = bmx_pkg::ST_FIN;
                end else if (last_lvl) begin
                    // present: restart from the root and take the counts down
                    n_root_cnt = r_root_cnt - CW'(1);
                    n_at_root  = 1'b1;
                    n_k0       = r_root_k0;
                    n_k1       = r_root_k1;
                    n_key      = r_key0;
                    n_lvl      = LVW'(KEY_BITS);
                    n_state    = bmx_pkg::ST_DUPD;
                end else begin
                    n_k0  = sel_k0;
                    n_k1  = sel_k1;
                    n_key = r_key << 1;
                    n_lvl = r_lvl - LVW'(1);
                end
            end

            bmx_pkg::ST_DUPD: begin
                if (!r_at_root) begin
                    mem_we = 1'b1;
                end
                n_node    = sel_ptr;
                n_at_root = 1'b0;
                n_k0      = sel_k0;
                n_k1      = sel_k1;
                n_cnt     = (sel_cnt != '0) ? (sel_cnt - CW'(1)) : sel_cnt;
                n_key     = r_key << 1;
                n_lvl     = r_lvl - LVW'(1);
                if (last_lvl) begin
                    n_state = bmx_pkg::ST_FLUSH;
                end
            end

            bmx_pkg::ST_QRY: begin
                n_k0   = take_opp ? opp_k0 : sel_k0;
                n_k1   = take_opp ? opp_k1 : sel_k1;
                n_best = (r_best << 1) | KEY_BITS'(take_opp);
                n_key  = r_key << 1;
                n_lvl  = r_lvl - LVW'(1);
                if (last_lvl) begin
                    n_state = bmx_pkg::ST_FIN;
                end
            end

            bmx_pkg::ST_FLUSH: begin
                // leaf write-back
                mem_we  = 1'b1;
                n_state = bmx_pkg::ST_FIN;
            end

            bmx_pkg::ST_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_max    = best_ext[bmx_pkg::VAL_W-1:0];
                    n_o_status = r_status;
                    n_state    = bmx_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bmx_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bmx_pkg::ST_IDLE;
            r_free     <= FREE_INIT;
            r_root_k0  <= '0;
            r_root_k1  <= '0;
            r_root_cnt <= '0;
            r_o_valid  <= 1'b0;
            r_at_root  <= 1'b1;
            r_lvl      <= '0;
        end else begin
            r_state    <= n_state;
            r_free     <= n_free;
            r_root_k0  <= n_root_k0;
            r_root_k1  <= n_root_k1;
            r_root_cnt <= n_root_cnt;
            r_o_valid  <= n_o_valid;
            r_at_root  <= n_at_root;
            r_lvl      <= n_lvl;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_key0     <= n_key0;
        r_best     <= n_best;
        r_node     <= n_node;
        r_k0       <= n_k0;
        r_k1       <= n_k1;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_o_max    <= n_o_max;
        r_o_status <= n_o_status;
    end

    assign o_valid   = r_o_valid;
    assign o_max_xor = r_o_max;
    assign o_status  = r_o_status;

endmodule
